// ===== hdl/etfi_pkg.sv =====
// Shared types and constants for the escape-time fractal iterator.
// No dependencies; imported by every module of the block.
`default_nettype none

package etfi_pkg;

   localparam int FRAC_BITS = 28;   // fraction bits of the Q4.28 format
   localparam int XW        = 10;   // pixel coordinate width
   localparam int NW        = 16;   // iteration counter width
   localparam int MW        = 32;   // multiplier operand width
   localparam int PW        = 2 * MW; // full product width
   localparam int CW        = 43;   // width of c = origin + pixel * step
   localparam int ZW        = 45;   // width of z, wide enough for one step past escape
   localparam int IW        = 3;    // register index width
   localparam int DW        = 32;   // register write data width

   // register indexes
   localparam logic [IW-1:0] CSR_MODE      = 3'd0;
   localparam logic [IW-1:0] CSR_MAX_ITER  = 3'd1;
   localparam logic [IW-1:0] CSR_ORIGIN_RE = 3'd2;
   localparam logic [IW-1:0] CSR_ORIGIN_IM = 3'd3;
   localparam logic [IW-1:0] CSR_STEP      = 3'd4;

   localparam logic MODE_MANDEL  = 1'b0;
   localparam logic MODE_BURNING = 1'b1;

   typedef struct packed {
      logic                   fractal_mode;
      logic [NW-1:0]          max_iterations;
      logic signed [DW-1:0]   origin_re;
      logic signed [DW-1:0]   origin_im;
      logic [DW-2:0]          pixel_step;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_RE,
      ST_MAP_IM,
      ST_LOAD_C,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_TEST,
      ST_UPDATE,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/etfi_csr.sv =====
// Configuration registers of the fractal iterator.
// Depends on etfi_pkg for the register indexes and the cfg_type struct.
`default_nettype none

module etfi_csr (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [etfi_pkg::IW-1:0] csr_index,
   input  wire logic [etfi_pkg::DW-1:0] csr_data,
   output etfi_pkg::cfg_type          cfg
);
   import etfi_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:      cfg_in.fractal_mode   = csr_data[0];
            CSR_MAX_ITER:  cfg_in.max_iterations = csr_data[NW-1:0];
            CSR_ORIGIN_RE: cfg_in.origin_re      = csr_data;
            CSR_ORIGIN_IM: cfg_in.origin_im      = csr_data;
            CSR_STEP:      cfg_in.pixel_step     = csr_data[DW-2:0];
            default:       cfg_in = cfg_ff;   // unknown index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fractal_mode   <= MODE_MANDEL;
         cfg_ff.max_iterations <= NW'(50);
         cfg_ff.origin_re      <= 32'hE000_0000;  // -2.0
         cfg_ff.origin_im      <= 32'hE800_0000;  // -1.5
         cfg_ff.pixel_step     <= 31'h0010_0000;  // 2^-8
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/etfi_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on etfi_pkg for the operand and product widths.
`default_nettype none

module etfi_mul (
   input  wire logic                         clock,
   input  wire logic signed [etfi_pkg::MW-1:0] mul_a,
   input  wire logic signed [etfi_pkg::MW-1:0] mul_b,
   output logic signed [etfi_pkg::PW-1:0]      prod
);
   import etfi_pkg::*;

   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;

   assign prod_in = PW'(mul_a) * PW'(mul_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ===== hdl/etfi_core.sv =====
// Sequencer and datapath registers: maps the pixel to c, then iterates z = z^2 + c
// through the shared multiplier (burning ship: abs of Re z, Im z). Depends on etfi_pkg and etfi_mul.
`default_nettype none

module etfi_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  etfi_pkg::cfg_type            cfg,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [etfi_pkg::XW-1:0] req_pixel_x,
   input  wire logic [etfi_pkg::XW-1:0] req_pixel_y,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [etfi_pkg::XW-1:0]      rsp_out_x,
   output logic [etfi_pkg::XW-1:0]      rsp_out_y,
   output logic [etfi_pkg::NW-1:0]      rsp_iterations,
   output logic                         rsp_escaped
);
   import etfi_pkg::*;

   localparam logic signed [ZW-1:0] TWO_FX  = ZW'(64'd2 << FRAC_BITS);
   localparam logic signed [ZW-1:0] FOUR_FX = ZW'(64'd4 << FRAC_BITS);

   state_type state_ff, state_in;

   logic [XW-1:0]        px_ff, px_in;
   logic [XW-1:0]        py_ff, py_in;
   logic signed [CW-1:0] cr_ff, cr_in;
   logic signed [CW-1:0] ci_ff, ci_in;
   logic signed [ZW-1:0] zr_ff, zr_in;
   logic signed [ZW-1:0] zi_ff, zi_in;
   logic signed [ZW-1:0] xx_ff, xx_in;
   logic signed [ZW-1:0] yy_ff, yy_in;
   logic [NW-1:0]        n_ff, n_in;
   logic                 esc_ff, esc_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [XW-1:0]        rsp_x_ff, rsp_x_in;
   logic [XW-1:0]        rsp_y_ff, rsp_y_in;
   logic [NW-1:0]        rsp_iter_ff, rsp_iter_in;
   logic                 rsp_esc_ff, rsp_esc_in;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] prod_sh;
   logic signed [ZW-1:0] prod_fx;
   logic signed [ZW-1:0] mag_sq;
   logic signed [MW-1:0] zr_nar, zi_nar, zr_abs, zi_abs;
   logic                 z_in_range;
   logic                 sq_escape;
   logic                 at_limit;
   logic                 out_free;

   etfi_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // floored fixed-point product; squares and cross term stay well inside ZW
   assign prod_sh = prod >>> FRAC_BITS;
   assign prod_fx = prod_sh[ZW-1:0];
   assign mag_sq  = xx_ff + prod_fx;

   assign z_in_range = (zr_ff < TWO_FX) && (zr_ff > -TWO_FX)
                    && (zi_ff < TWO_FX) && (zi_ff > -TWO_FX);
   assign sq_escape  = (mag_sq >= FOUR_FX);
   assign at_limit   = (n_ff >= cfg.max_iterations);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // only read once z is known to lie inside (-2, 2)
   assign zr_nar = zr_ff[MW-1:0];
   assign zi_nar = zi_ff[MW-1:0];
   assign zr_abs = zr_nar[MW-1] ? -zr_nar : zr_nar;
   assign zi_abs = zi_nar[MW-1] ? -zi_nar : zi_nar;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MAP_RE;
         ST_MAP_RE: state_in = ST_MAP_IM;
         ST_MAP_IM: state_in = ST_LOAD_C;
         ST_LOAD_C: state_in = ST_SQ_RE;
         ST_SQ_RE:  state_in = z_in_range ? ST_SQ_IM : ST_FINISH;
         ST_SQ_IM:  state_in = ST_TEST;
         ST_TEST:   state_in = (sq_escape || at_limit) ? ST_FINISH : ST_UPDATE;
         ST_UPDATE: state_in = ST_SQ_RE;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: handshake and multiplier operands
   always_comb begin
      req_ready = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_MAP_RE: begin
            mul_a = {{(MW-XW){1'b0}}, px_ff};
            mul_b = {1'b0, cfg.pixel_step};
         end
         ST_MAP_IM: begin
            mul_a = {{(MW-XW){1'b0}}, py_ff};
            mul_b = {1'b0, cfg.pixel_step};
         end
         ST_SQ_RE: begin
            mul_a = zr_nar;
            mul_b = zr_nar;
         end
         ST_SQ_IM: begin
            mul_a = zi_nar;
            mul_b = zi_nar;
         end
         ST_TEST: begin
            mul_a = (cfg.fractal_mode == MODE_BURNING) ? zr_abs : zr_nar;
            mul_b = (cfg.fractal_mode == MODE_BURNING) ? zi_abs : zi_nar;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      px_in  = px_ff;
      py_in  = py_ff;
      cr_in  = cr_ff;
      ci_in  = ci_ff;
      zr_in  = zr_ff;
      zi_in  = zi_ff;
      xx_in  = xx_ff;
      yy_in  = yy_ff;
      n_in   = n_ff;
      esc_in = esc_ff;
      case (state_ff)
         ST_IDLE: begin
            px_in  = req_pixel_x;
            py_in  = req_pixel_y;
            zr_in  = '0;
            zi_in  = '0;
            n_in   = '0;
            esc_in = 1'b0;
         end
         ST_MAP_IM: cr_in = CW'(cfg.origin_re) + prod[CW-1:0];
         ST_LOAD_C: ci_in = CW'(cfg.origin_im) + prod[CW-1:0];
         ST_SQ_RE:  if (!z_in_range) esc_in = 1'b1;
         ST_SQ_IM:  xx_in = prod_fx;
         ST_TEST: begin
            yy_in  = prod_fx;
            esc_in = sq_escape;
         end
         ST_UPDATE: begin
            zr_in = xx_ff - yy_ff + ZW'(cr_ff);
            zi_in = (prod_fx <<< 1) + ZW'(ci_ff);
            n_in  = n_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // result register, free to take a new result while the next pixel starts
   always_comb begin
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_iter_in  = rsp_iter_ff;
      rsp_esc_in   = rsp_esc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_x_in     = px_ff;
         rsp_y_in     = py_ff;
         rsp_iter_in  = esc_ff ? NW'(n_ff - 1'b1) : n_ff;
         rsp_esc_in   = esc_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      xx_ff       <= xx_in;
      yy_ff       <= yy_in;
      n_ff        <= n_in;
      esc_ff      <= esc_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_iter_ff <= rsp_iter_in;
      rsp_esc_ff  <= rsp_esc_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_iterations = rsp_iter_ff;
   assign rsp_escaped    = rsp_esc_ff;

`ifndef ASSERT_OFF
   // squaring only ever starts on a z that passed the range check
   a_sq_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ_IM) |-> z_in_range)
      else $error("squaring z outside (-2, 2)");

   // an accepted transaction always starts the pixel mapping
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MAP_RE))
      else $error("accepted transaction did not start mapping");

   // a finished pixel lands in the result register as the sequencer returns to idle
   a_finish_hands_off: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished pixel not handed to result register");

   // z is only updated straight after the escape and limit test
   a_update_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> ($past(state_ff) == ST_TEST))
      else $error("z update without preceding test");
`endif

endmodule

`default_nettype wire

// ===== hdl/escape_time_fractal_iterator_top.sv =====
// Escape-time fractal iterator (Mandelbrot / burning ship), Q4.28 fixed point.
// Sequence: map the pixel to c, then iterate on one shared 32x32 multiplier (three
// products per iteration), then finish. One pixel is worked at a time; the next is
// accepted as soon as the result sits in the output register.
// Reset: synchronous, clears the sequencer and result valid, loads register defaults.
`default_nettype none

module escape_time_fractal_iterator_top (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [etfi_pkg::IW-1:0] csr_index,
   input  wire logic [etfi_pkg::DW-1:0] csr_data,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [etfi_pkg::XW-1:0] req_pixel_x,
   input  wire logic [etfi_pkg::XW-1:0] req_pixel_y,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [etfi_pkg::XW-1:0]      rsp_out_x,
   output logic [etfi_pkg::XW-1:0]      rsp_out_y,
   output logic [etfi_pkg::NW-1:0]      rsp_iterations,
   output logic                         rsp_escaped
);
   import etfi_pkg::*;

   cfg_type cfg;

   etfi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   etfi_core u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_iterations (rsp_iterations),
      .rsp_escaped    (rsp_escaped)
   );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for escape_time_fractal_iterator_top.
// Depends on hdl/etfi_pkg.sv and the block's RTL; predicts every pixel's escape count
// in fixed point and checks each rsp transaction against it.
`timescale 1ns / 1ps

module tb_top;
   import etfi_pkg::*;

   typedef struct packed {
      logic [XW-1:0] x;
      logic [XW-1:0] y;
   } pixel_req_t;

   typedef struct packed {
      logic [XW-1:0] x;
      logic [XW-1:0] y;
      logic [NW-1:0] iters;
      logic          escaped;
   } pixel_result_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_valid = 1'b0;
   logic [IW-1:0] csr_index = '0;
   logic [DW-1:0] csr_data = '0;
   logic          req_valid = 1'b0;
   logic [XW-1:0] req_pixel_x = '0;
   logic [XW-1:0] req_pixel_y = '0;
   logic          rsp_ready = 1'b0;
   logic          csr_ready;
   logic          req_ready;
   logic          rsp_valid;
   logic [XW-1:0] rsp_out_x;
   logic [XW-1:0] rsp_out_y;
   logic [NW-1:0] rsp_iterations;
   logic          rsp_escaped;

   escape_time_fractal_iterator_top dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_iterations (rsp_iterations),
      .rsp_escaped    (rsp_escaped)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   pixel_req_t    pixel_backlog[$];
   pixel_result_t awaited_pixels[$];
   cfg_type       view;
   pixel_req_t    next_pix;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            outstanding = 0;
   int            idle_cycles = 0;
   int            mismatch_count = 0;
   int            pixels_checked = 0;
   int            escaped_count = 0;
   int            deepest_count = 0;
   int            csr_writes = 0;

   // floor(a*b / 2^FRAC_BITS) from the exact product
   function automatic logic signed [63:0] q28_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic [127:0] p;
      p = {{64{a[63]}}, a} * {{64{b[63]}}, b};
      return p[FRAC_BITS+63:FRAC_BITS];
   endfunction

   function automatic bit outside_radius(input logic signed [63:0] zr,
                                         input logic signed [63:0] zi);
      logic [63:0] ar;
      logic [63:0] ai;
      logic [63:0] sq;
      ar = zr[63] ? -zr : zr;
      ai = zi[63] ? -zi : zi;
      if (ar >= (64'd2 << FRAC_BITS) || ai >= (64'd2 << FRAC_BITS))
         return 1'b1;
      sq = q28_mul(zr, zr) + q28_mul(zi, zi);
      return sq >= (64'd4 << FRAC_BITS);
   endfunction

   function automatic pixel_result_t escape_time(input pixel_req_t pix, input cfg_type v);
      pixel_result_t    res;
      logic signed [63:0] cr;
      logic signed [63:0] ci;
      logic signed [63:0] zr;
      logic signed [63:0] zi;
      logic signed [63:0] xx;
      logic signed [63:0] yy;
      logic signed [63:0] xy;
      int               n;
      int               cnt;
      bit               esc;
      bit               done;
      cr = {{32{v.origin_re[DW-1]}}, v.origin_re} + {54'd0, pix.x} * {33'd0, v.pixel_step};
      ci = {{32{v.origin_im[DW-1]}}, v.origin_im} + {54'd0, pix.y} * {33'd0, v.pixel_step};
      zr = '0;
      zi = '0;
      n = 0;
      esc = 1'b0;
      done = 1'b0;
      while (!done) begin
         if (outside_radius(zr, zi)) begin
            esc = 1'b1;
            done = 1'b1;
         end else if (n >= int'(v.max_iterations)) begin
            done = 1'b1;
         end else begin
            if (v.fractal_mode == MODE_BURNING) begin
               if (zr < 0) zr = -zr;
               if (zi < 0) zi = -zi;
            end
            xx = q28_mul(zr, zr);
            yy = q28_mul(zi, zi);
            xy = q28_mul(zr, zi);
            zr = xx - yy + cr;
            zi = (xy <<< 1) + ci;
            n++;
         end
      end
      cnt = esc ? n - 1 : n;
      res.x = pix.x;
      res.y = pix.y;
      res.iters = cnt[NW-1:0];
      res.escaped = esc;
      return res;
   endfunction

   // driver: valid holds until the transaction goes through
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_pix = pixel_backlog.pop_front();
            req_valid <= 1'b1;
            req_pixel_x <= next_pix.x;
            req_pixel_y <= next_pix.y;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // monitor: register shadow, prediction at acceptance, result check
   always @(posedge clock) begin : monitor
      pixel_result_t want;
      pixel_req_t    pix;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (reset) begin
         view.fractal_mode = MODE_MANDEL;
         view.max_iterations = 16'd50;
         view.origin_re = 32'shE000_0000;
         view.origin_im = 32'shE800_0000;
         view.pixel_step = 31'h0010_0000;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:      view.fractal_mode = csr_data[0];
               CSR_MAX_ITER:  view.max_iterations = csr_data[NW-1:0];
               CSR_ORIGIN_RE: view.origin_re = csr_data;
               CSR_ORIGIN_IM: view.origin_im = csr_data;
               CSR_STEP:      view.pixel_step = csr_data[DW-2:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_pixels.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected result x=%0d y=%0d", $realtime, rsp_out_x,
                           rsp_out_y);
               mismatch_count++;
            end else begin
               want = awaited_pixels.pop_front();
               outstanding--;
               pixels_checked++;
               if (want.escaped) escaped_count++;
               if (int'(want.iters) > deepest_count) deepest_count = want.iters;
               if (rsp_out_x !== want.x || rsp_out_y !== want.y
                   || rsp_iterations !== want.iters || rsp_escaped !== want.escaped) begin
                  if (mismatch_count < 10) begin
                     $write("%0t: mismatch exp x=%0d y=%0d it=%0d esc=%0d,",
                            $realtime, want.x, want.y, want.iters, want.escaped);
                     $display(" got x=%0d y=%0d it=%0d esc=%0d",
                              rsp_out_x, rsp_out_y, rsp_iterations, rsp_escaped);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            pix.x = req_pixel_x;
            pix.y = req_pixel_y;
            awaited_pixels.push_back(escape_time(pix, view));
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < 20 * int'(view.max_iterations) + 5000)
         @(posedge clock);
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic csr_write(input logic [IW-1:0] idx, input logic [DW-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   // unused upper data bits carry noise, the block should mask them
   task automatic set_view(input logic m, input logic [NW-1:0] lim,
                           input logic [DW-1:0] ore, input logic [DW-1:0] oim,
                           input logic [DW-2:0] stp);
      csr_write(CSR_MODE, DW'({$urandom(), m}));
      csr_write(CSR_MAX_ITER, DW'({$urandom(), lim}));
      csr_write(CSR_ORIGIN_RE, ore);
      csr_write(CSR_ORIGIN_IM, oim);
      csr_write(CSR_STEP, DW'({$urandom(), stp}));
   endtask

   task automatic queue_pixel(input logic [XW-1:0] x, input logic [XW-1:0] y);
      pixel_req_t p;
      p.x = x;
      p.y = y;
      pixel_backlog.push_back(p);
      outstanding++;
   endtask

   task automatic drain();
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic random_view();
      int   pick;
      logic m;
      int   lim;
      int   ore;
      int   oim;
      int   stp;
      pick = $urandom_range(0, 9);
      m = $urandom_range(0, 1) ? MODE_BURNING : MODE_MANDEL;
      lim = (pick < 7) ? $urandom_range(1, 64) : $urandom_range(65, 255);
      // window roughly over the interesting part of the plane
      ore = int'($urandom_range(0, 805306368)) - 671088640;
      oim = int'($urandom_range(0, 536870912)) - 402653184;
      stp = $urandom_range(1 << 12, 1 << 21);
      if (pick == 9) begin
         lim = $urandom_range(1, 32);
         ore = $urandom();
         oim = $urandom();
         stp = $urandom() >> 1;
      end
      set_view(m, NW'(lim), ore, oim, (DW-1)'(stp));
   endtask

   initial begin : sequencer
      int n;
      int leftover;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset: corners and c = 0 (never escapes, runs to the limit)
      queue_pixel(0, 0);
      queue_pixel(1023, 1023);
      queue_pixel(0, 1023);
      queue_pixel(1023, 0);
      queue_pixel(512, 384);
      drain();

      // writes to unused indexes must leave the view unchanged
      for (int i = int'(CSR_STEP) + 1; i < (1 << IW); i++)
         csr_write(i[IW-1:0], $urandom());
      queue_pixel(512, 384);
      drain();

      // c = 1: escapes right after the second update, on the last permitted one
      set_view(MODE_MANDEL, 2, 32'h1000_0000, 32'h0000_0000, 31'h0);
      queue_pixel(5, 7);
      drain();
      csr_write(CSR_MAX_ITER, 1);
      queue_pixel(1023, 511);
      drain();

      // zero limit, smallest step
      csr_write(CSR_MAX_ITER, 0);
      csr_write(CSR_STEP, 1);
      queue_pixel(1023, 1023);
      drain();

      // burning ship at the largest limit: one interior point, then a ship window
      set_view(MODE_BURNING, 16'hFFFF, 32'h0, 32'h0, 31'h0);
      queue_pixel(1023, 0);
      drain();
      set_view(MODE_BURNING, 100, 32'hE333_3333, 32'hFE66_6666, 31'h0004_0000);
      queue_pixel(0, 0);
      queue_pixel(100, 200);
      queue_pixel(1023, 1023);
      queue_pixel(300, 50);
      drain();

      // extreme origins and largest step
      set_view(MODE_MANDEL, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      queue_pixel(0, 0);
      queue_pixel(1023, 1023);
      queue_pixel(1, 0);
      drain();
      set_view(MODE_MANDEL, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
      queue_pixel(0, 0);
      queue_pixel(0, 1023);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 11;
               recv_idle_pct = 79;
            end
            1: begin
               send_idle_pct = 79;
               recv_idle_pct = 11;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int v = 0; v < 6; v++) begin
            random_view();
            if (v == 0)
               csr_write(IW'($urandom_range(int'(CSR_STEP) + 1, (1 << IW) - 1)), $urandom());
            n = $urandom_range(56, 92);
            repeat (n) queue_pixel(XW'($urandom_range(0, 1023)), XW'($urandom_range(0, 1023)));
            if (v == 2) begin
               // sender holds off until the block has emptied, same view
               drain();
               repeat (n / 2)
                  queue_pixel(XW'($urandom_range(0, 1023)), XW'($urandom_range(0, 1023)));
            end
            drain();
         end
      end

      drain();
      repeat (60) @(posedge clock);
      leftover = awaited_pixels.size();
      $display("checked %0d pixels, %0d escaped, deepest count %0d, %0d register writes",
               pixels_checked, escaped_count, deepest_count, csr_writes);
      $display("mismatches %0d, expectations left over %0d", mismatch_count, leftover);
      if (mismatch_count == 0 && leftover == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/etfi_pkg.sv
hdl/etfi_csr.sv
hdl/etfi_mul.sv
hdl/etfi_core.sv
hdl/escape_time_fractal_iterator_top.sv
dv/tb_top.sv
